>>> hdl/lfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED flasher package
// Shared constants, types and the seven-segment decoder of the LED flasher.
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int unsigned FieldBits = 10;
  localparam logic [FieldBits-1:0] ShowLimit = 10'd999;

  localparam logic [1:0] EdgePause = 2'b01;
  localparam logic [1:0] EdgeLoad  = 2'b10;

  localparam logic [7:0] ModePaused = 8'h0c;
  localparam logic [7:0] ModeBlank  = 8'hff;

  typedef struct packed {
    logic [1:0]           led_pattern;
    logic                 clear_capture;
    logic                 paused;
    logic [FieldBits-1:0] shown;
    logic [FieldBits-1:0] shown_period;
    logic                 period_changed;
  } ctrl_res_t;

  typedef struct packed {
    logic [7:0] digit_mode;
    logic [7:0] digit_hundreds;
    logic [7:0] digit_tens;
    logic [7:0] digit_ones;
  } disp_res_t;

  // Active-low segments, dp and g down to a.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hc0;
      4'd1:    seg = 8'hf9;
      4'd2:    seg = 8'ha4;
      4'd3:    seg = 8'hb0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hf8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = 8'hff;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lfd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED flasher control
// Holds pause, period, millisecond count and LED pattern, and updates them
// once for every poll word that moves on to the result register.
// ----------------------------------------------------------------------------
module lfd_ctrl
  import lfd_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [1:0]           button_edges_i,
  input  wire logic [FieldBits-1:0] switch_value_i,
  input  wire logic                 ms_tick_i,
  output ctrl_res_t                 res_o
);

  localparam logic [PERIOD_BITS-1:0] PeriodReset = PERIOD_BITS'(100);

  logic                   pause_q, pause_d;
  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic [PERIOD_BITS-1:0] elapsed_q, elapsed_d;
  logic [1:0]             pattern_q, pattern_d;
  logic [PERIOD_BITS-1:0] reported_q;

  logic [PERIOD_BITS+FieldBits-1:0] sw_wide;
  logic [PERIOD_BITS+FieldBits-1:0] period_wide;
  logic [PERIOD_BITS-1:0]           elapsed_inc;
  logic                             flip;

  assign sw_wide     = {{PERIOD_BITS{1'b0}}, switch_value_i};
  assign period_wide = {{FieldBits{1'b0}}, period_d};

  always_comb begin
    pause_d  = pause_q;
    period_d = period_q;
    if (button_edges_i == EdgePause) begin
      pause_d = ~pause_q;
    end else if (button_edges_i == EdgeLoad) begin
      period_d = sw_wide[PERIOD_BITS-1:0];
    end

    elapsed_inc = elapsed_q;
    if (ms_tick_i && (elapsed_q != '1)) begin
      elapsed_inc = elapsed_q + 1'b1;
    end

    flip      = !pause_d && (elapsed_inc >= period_d);
    pattern_d = flip ? ~pattern_q : pattern_q;
    elapsed_d = flip ? '0 : elapsed_inc;
  end

  always_comb begin
    res_o.led_pattern    = pattern_d;
    res_o.clear_capture  = (button_edges_i != 2'b00);
    res_o.paused         = pause_d;
    res_o.shown_period   = period_wide[FieldBits-1:0];
    res_o.shown          = (period_wide > (PERIOD_BITS+FieldBits)'(ShowLimit)) ?
                           ShowLimit : period_wide[FieldBits-1:0];
    res_o.period_changed = (period_d != reported_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q    <= 1'b0;
      period_q   <= PeriodReset;
      elapsed_q  <= '0;
      pattern_q  <= 2'b01;
      reported_q <= '0;
    end else if (step_i) begin
      pause_q    <= pause_d;
      period_q   <= period_d;
      elapsed_q  <= elapsed_d;
      pattern_q  <= pattern_d;
      reported_q <= period_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/lfd_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED flasher display decoder
// Splits the clamped period into decimal digits by reciprocal multiplication
// and maps them, and the pause mark, to seven-segment patterns.
// ----------------------------------------------------------------------------
module lfd_display
  import lfd_pkg::*;
(
  input  wire logic [FieldBits-1:0] shown_i,
  input  wire logic                 paused_i,
  output disp_res_t                 res_o
);

  logic [15:0] hund_prod;
  logic [3:0]  hund;
  logic [9:0]  rest_wide;
  logic [6:0]  rest;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  ones_wide;

  // Multiplying by 41/4096 and by 205/2048 is exact over the values shown.
  always_comb begin
    hund_prod = 16'(shown_i) * 16'd41;
    hund      = hund_prod[15:12];
    rest_wide = shown_i - 10'(hund) * 10'd100;
    rest      = rest_wide[6:0];
    tens_prod = 15'(rest) * 15'd205;
    tens      = tens_prod[14:11];
    ones_wide = rest - 7'(tens) * 7'd10;
  end

  always_comb begin
    res_o.digit_mode     = paused_i ? ModePaused : ModeBlank;
    res_o.digit_hundreds = seg_of(hund);
    res_o.digit_tens     = seg_of(tens);
    res_o.digit_ones     = seg_of(ones_wide[3:0]);
  end

endmodule
`default_nettype wire

>>> hdl/led_flasher_with_display.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED flasher with display
// Top level: input register, flasher control, display decoder and result
// register on a pair of streaming ports.
// ----------------------------------------------------------------------------
// Each input word is one poll and gives exactly one result word. The block
// takes one word per clock cycle while the result port is not stalled: the
// poll passes an input register, the state update and the decimal split of
// the display are done in the cycle that moves it to the result register,
// and the result waits there until it is taken. The input side stays ready
// while the input register is empty or the result register is empty or being emptied.
module led_flasher_with_display
  import lfd_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // button_edges [1:0], switch_value [11:2], ms_tick [12], zero [15:13]
  input  wire logic [15:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // led_pattern [1:0], clear_capture [2], digit_mode [10:3],
  // digit_hundreds [18:11], digit_tens [26:19], digit_ones [34:27],
  // shown_period [44:35], period_changed [45], zero [47:46]
  output logic [47:0]      m_axis_tdata_o
);

  logic                 in_valid_q;
  logic [1:0]           edges_q;
  logic [FieldBits-1:0] switch_q;
  logic                 tick_q;

  logic        out_valid_q;
  logic [47:0] out_data_q, out_data_d;

  logic      out_ready;
  logic      advance;
  ctrl_res_t ctrl_res;
  disp_res_t disp_res;

  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      edges_q  <= s_axis_tdata_i[1:0];
      switch_q <= s_axis_tdata_i[11:2];
      tick_q   <= s_axis_tdata_i[12];
    end
  end

  lfd_ctrl #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .step_i         (advance),
    .button_edges_i (edges_q),
    .switch_value_i (switch_q),
    .ms_tick_i      (tick_q),
    .res_o          (ctrl_res)
  );

  lfd_display u_display (
    .shown_i  (ctrl_res.shown),
    .paused_i (ctrl_res.paused),
    .res_o    (disp_res)
  );

  assign out_data_d = {2'b00,
                       ctrl_res.period_changed,
                       ctrl_res.shown_period,
                       disp_res.digit_ones,
                       disp_res.digit_tens,
                       disp_res.digit_hundreds,
                       disp_res.digit_mode,
                       ctrl_res.clear_capture,
                       ctrl_res.led_pattern};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  a_led_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_data_q[1:0] == 2'b01 || out_data_q[1:0] == 2'b10))
    else $error("LED pattern is not one of the two flash states.");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_data_q[10:3] == ModePaused || out_data_q[10:3] == ModeBlank))
    else $error("Mode digit holds neither the pause mark nor blank.");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> in_valid_q)
    else $error("Accepted word did not reach the input register.");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("Input accepted while both registers are held.");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("Result register empty after a word moved on.");

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED flasher with display testbench
// Streams button, switch and tick polls into the flasher and checks every
// result word against a cycle-free model of the pause, period, flash and
// display logic, under random idling on both ports and long stalls.
// ----------------------------------------------------------------------------
module testbench;
  import lfd_pkg::*;

  localparam int unsigned CountBits  = 10;
  localparam logic [CountBits-1:0] CountFull = '1;
  localparam logic [1:0] EdgeNone = 2'b00;
  localparam logic [1:0] EdgeBoth = 2'b11;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 10;
  // Active-low segment codes for the digits nine down to zero.
  localparam logic [79:0] SegRom = {8'h90, 8'h80, 8'hf8, 8'h82, 8'h92,
                                    8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0};

  typedef struct packed {
    logic [1:0]           led_pattern;
    logic                 clear_capture;
    logic [7:0]           digit_mode;
    logic [7:0]           digit_hundreds;
    logic [7:0]           digit_tens;
    logic [7:0]           digit_ones;
    logic [CountBits-1:0] shown_period;
    logic                 period_changed;
  } flash_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  logic [15:0] polls_pending[$];
  flash_word_t words_due[$];

  logic                 st_paused = 1'b0;
  logic [CountBits-1:0] st_period = 10'd100;
  logic [CountBits-1:0] st_elapsed = '0;
  logic [1:0]           st_pattern = 2'b01;
  logic [CountBits-1:0] st_reported = '0;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 77;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  led_flasher_with_display u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic flash_word_t flasher_step(input logic [15:0] poll);
    logic [1:0]           edges;
    logic [CountBits-1:0] sw;
    logic                 tick;
    int unsigned          clamped;
    flash_word_t          res;
    edges = poll[1:0];
    sw    = poll[11:2];
    tick  = poll[12];
    res.period_changed = 1'b0;
    if (edges == EdgePause) begin
      st_paused = !st_paused;
    end else if (edges == EdgeLoad) begin
      st_period = sw;
    end
    if (st_period != st_reported) begin
      res.period_changed = 1'b1;
      st_reported = st_period;
    end
    clamped = 32'((st_period > ShowLimit) ? ShowLimit : st_period);
    if (tick && st_elapsed != CountFull) begin
      st_elapsed = st_elapsed + 1'b1;
    end
    if (!st_paused && st_elapsed >= st_period) begin
      st_pattern = st_pattern ^ 2'b11;
      st_elapsed = '0;
    end
    res.led_pattern    = st_pattern;
    res.clear_capture  = (edges != EdgeNone);
    res.digit_mode     = st_paused ? ModePaused : ModeBlank;
    res.digit_hundreds = SegRom[(clamped / 100) * 8 +: 8];
    res.digit_tens     = SegRom[((clamped / 10) % 10) * 8 +: 8];
    res.digit_ones     = SegRom[(clamped % 10) * 8 +: 8];
    res.shown_period   = st_period;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        words_due.push_back(flasher_step(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (polls_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= polls_pending.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HoldCycles;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    flash_word_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (words_due.size() == 0) begin
        $error("result word 0x%h arrived with nothing expected", m_tdata);
        mismatches++;
      end else begin
        want = words_due.pop_front();
        check_field("led_pattern", 32'(want.led_pattern), 32'(m_tdata[1:0]));
        check_field("clear_capture", 32'(want.clear_capture), 32'(m_tdata[2]));
        check_field("digit_mode", 32'(want.digit_mode), 32'(m_tdata[10:3]));
        check_field("digit_hundreds", 32'(want.digit_hundreds), 32'(m_tdata[18:11]));
        check_field("digit_tens", 32'(want.digit_tens), 32'(m_tdata[26:19]));
        check_field("digit_ones", 32'(want.digit_ones), 32'(m_tdata[34:27]));
        check_field("shown_period", 32'(want.shown_period), 32'(m_tdata[44:35]));
        check_field("period_changed", 32'(want.period_changed), 32'(m_tdata[45]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_poll(input logic [1:0] edges, input logic [CountBits-1:0] sw,
                            input logic tick);
    polls_pending.push_back({3'b000, tick, sw, edges});
  endtask

  task automatic drain();
    while (polls_pending.size() != 0 || s_tvalid || words_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [CountBits-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return CountBits'($urandom_range(12));
    end else if (r < 88) begin
      return CountBits'($urandom_range(1023));
    end else if (r < 94) begin
      return CountFull;
    end
    return CountBits'(999 + $urandom_range(1));
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned issued;
    int unsigned run;
    int unsigned tick_pct;
    int unsigned r;
    issued = 0;
    while (issued < count) begin
      r = $urandom_range(99);
      if (r < 65) begin
        queue_poll(EdgeLoad, pick_period(), 1'($urandom_range(1)));
        run = $urandom_range(40, 5);
        tick_pct = $urandom_range(100, 30);
        repeat (run) begin
          queue_poll(($urandom_range(99) < 4) ? EdgePause : EdgeNone,
                     CountBits'($urandom_range(1023)), $urandom_range(99) < tick_pct);
        end
        issued += run + 1;
      end else if (r < 78) begin
        run = $urandom_range(20, 1);
        queue_poll(EdgePause, CountBits'($urandom_range(1023)), 1'($urandom_range(1)));
        repeat (run) begin
          queue_poll(EdgeNone, CountBits'($urandom_range(1023)), 1'($urandom_range(1)));
        end
        queue_poll(EdgePause, CountBits'($urandom_range(1023)), 1'($urandom_range(1)));
        issued += run + 2;
      end else begin
        queue_poll(2'($urandom_range(3)), CountBits'($urandom_range(1023)),
                   1'($urandom_range(1)));
        issued++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_poll(EdgeNone, 10'd0, 1'b0);
    queue_poll(EdgeLoad, 10'd0, 1'b0);
    queue_poll(EdgeNone, 10'd1023, 1'b1);
    queue_poll(EdgeNone, 10'd0, 1'b0);
    queue_poll(EdgeLoad, 10'd1023, 1'b1);
    queue_poll(EdgeLoad, 10'd999, 1'b1);
    queue_poll(EdgeLoad, 10'd1000, 1'b0);
    queue_poll(EdgeLoad, 10'd1, 1'b1);
    queue_poll(EdgeNone, 10'd0, 1'b1);
    queue_poll(EdgeNone, 10'd0, 1'b1);
    queue_poll(EdgePause, 10'd1023, 1'b1);
    queue_poll(EdgeNone, 10'd0, 1'b1);
    queue_poll(EdgeNone, 10'd0, 1'b1);
    queue_poll(EdgeBoth, 10'd5, 1'b1);
    queue_poll(EdgeBoth, 10'd1023, 1'b0);
    queue_poll(EdgePause, 10'd0, 1'b0);
    queue_poll(EdgeLoad, 10'd512, 1'b0);
    queue_poll(EdgeLoad, 10'd341, 1'b1);
    queue_poll(EdgeLoad, 10'd682, 1'b1);
    queue_poll(EdgeLoad, 10'd3, 1'b1);
    queue_poll(EdgeNone, 10'd0, 1'b1);
    queue_poll(EdgeNone, 10'd0, 1'b0);
    queue_poll(EdgeNone, 10'd0, 1'b1);
    queue_poll(EdgeLoad, 10'd307, 1'b1);
    queue_random(180);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 34;
    queue_random(180);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    if (!st_paused) begin
      queue_poll(EdgePause, CountBits'($urandom_range(1023)), 1'b1);
    end
    repeat (1030) begin
      queue_poll(EdgeNone, CountBits'($urandom_range(1023)), 1'b1);
    end
    queue_poll(EdgePause, CountBits'($urandom_range(1023)), 1'b0);
    queue_poll(EdgeNone, CountBits'($urandom_range(1023)), 1'b1);
    queue_random(100);
    drain();

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
